FILE: hdl/umsbt_pkg.sv
package umsbt_pkg;

   typedef enum logic [2:0] {
      PH_LISTEN,
      PH_CMD,
      PH_RX_GO,
      PH_RX_DATA,
      PH_TX_GO,
      PH_TX_ACK,
      PH_RX_SEND,
      PH_TX_SEND
   } phase_type;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic [7:0] CMD_RECEIVE     = 8'h01;
   localparam logic [7:0] CMD_SEND        = 8'h02;
   localparam logic [7:0] REPLY_NOT_READY = 8'h00;
   localparam logic [7:0] REPLY_UNKNOWN   = 8'h80;
   localparam logic [7:0] REPLY_BAD_SUM   = 8'hFF;
   localparam logic [7:0] REPLY_OK        = 8'h00;
   localparam logic [7:0] ANSWER_DONE     = 8'h00;

   typedef struct packed {
      logic       tx_load;
      logic       rx_clear;
      logic       rx_store;
      logic       burst_start;
      logic       burst_step;
      logic       burst_final;
      logic       sel_rx;
      logic       reply;
      logic       reply_addr;
      logic [7:0] reply_byte;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic cnt_full;
      logic sum_match;
      logic addr_match;
   } dp_stat_type;

endpackage

FILE: hdl/umsbt_req_if.sv
interface umsbt_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] frame_byte;
   logic       frame_bit9;
   logic [3:0] load_index;
   logic [7:0] load_value;
   logic       rx_ready;
   logic       tx_ready;

   modport source (
      output valid, command, frame_byte, frame_bit9, load_index, load_value,
             rx_ready, tx_ready,
      input  ready
   );
   modport sink (
      input  valid, command, frame_byte, frame_bit9, load_index, load_value,
             rx_ready, tx_ready,
      output ready
   );
endinterface

FILE: hdl/umsbt_rsp_if.sv
interface umsbt_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] out_byte;
   logic [3:0] out_index;
   logic       last;

   modport source (
      output valid, out_kind, out_byte, out_index, last,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_byte, out_index, last,
      output ready
   );
endinterface

FILE: hdl/umsbt_ctrl.sv
module umsbt_ctrl
   import umsbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_bit9,
   input  logic        req_rx_ready,
   input  logic        req_tx_ready,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   phase_type state_ff;
   phase_type state_in;
   logic      waiting;
   logic      frame_acc;

   assign waiting   = (state_ff != PH_RX_SEND) && (state_ff != PH_TX_SEND);
   assign req_ready = waiting && stat.out_free;
   assign frame_acc = req_valid && req_ready && (req_command == OP_FRAME);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_LISTEN;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PH_LISTEN: begin
            if (frame_acc && req_frame_bit9 && stat.addr_match) begin
               state_in = PH_CMD;
            end
         end
         PH_CMD: begin
            if (frame_acc) begin
               if (req_frame_bit9) begin
                  state_in = PH_LISTEN;
               end else if (req_frame_byte == CMD_RECEIVE) begin
                  state_in = PH_RX_GO;
               end else if (req_frame_byte == CMD_SEND) begin
                  state_in = PH_TX_GO;
               end else begin
                  state_in = PH_LISTEN;
               end
            end
         end
         PH_RX_GO: begin
            if (frame_acc) begin
               state_in = req_frame_bit9 ? PH_LISTEN : PH_RX_DATA;
            end
         end
         PH_RX_DATA: begin
            if (frame_acc && stat.cnt_full && stat.sum_match) begin
               state_in = PH_RX_SEND;
            end
         end
         PH_TX_GO: begin
            if (frame_acc) begin
               state_in = req_frame_bit9 ? PH_LISTEN : PH_TX_SEND;
            end
         end
         PH_TX_ACK: begin
            if (frame_acc) begin
               state_in = (req_frame_byte == ANSWER_DONE) ? PH_LISTEN : PH_TX_SEND;
            end
         end
         PH_RX_SEND: begin
            if (stat.out_free && stat.cnt_full) begin
               state_in = PH_LISTEN;
            end
         end
         PH_TX_SEND: begin
            if (stat.out_free && stat.cnt_full) begin
               state_in = PH_TX_ACK;
            end
         end
         default: state_in = PH_LISTEN;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd         = '0;
      cmd.tx_load = req_valid && req_ready && (req_command == OP_LOAD);
      unique case (state_ff) inside
         PH_LISTEN: begin
            if (frame_acc && req_frame_bit9 && stat.addr_match) begin
               cmd.reply      = 1'b1;
               cmd.reply_addr = 1'b1;
            end
         end
         PH_CMD: begin
            if (frame_acc && !req_frame_bit9) begin
               cmd.reply = 1'b1;
               if (req_frame_byte == CMD_RECEIVE) begin
                  cmd.reply_byte = req_rx_ready ? CMD_RECEIVE : REPLY_NOT_READY;
               end else if (req_frame_byte == CMD_SEND) begin
                  cmd.reply_byte = req_tx_ready ? CMD_SEND : REPLY_NOT_READY;
               end else begin
                  cmd.reply_byte = REPLY_UNKNOWN;
               end
            end
         end
         PH_RX_GO: begin
            cmd.rx_clear = frame_acc && !req_frame_bit9;
         end
         PH_RX_DATA: begin
            if (frame_acc) begin
               if (!stat.cnt_full) begin
                  cmd.rx_store = 1'b1;
               end else if (stat.sum_match) begin
                  cmd.burst_start = 1'b1;
                  cmd.sel_rx      = 1'b1;
               end else begin
                  cmd.reply      = 1'b1;
                  cmd.reply_byte = REPLY_BAD_SUM;
                  cmd.rx_clear   = 1'b1;
               end
            end
         end
         PH_TX_GO: begin
            cmd.burst_start = frame_acc && !req_frame_bit9;
         end
         PH_TX_ACK: begin
            cmd.burst_start = frame_acc && (req_frame_byte != ANSWER_DONE);
         end
         PH_RX_SEND, PH_TX_SEND: begin
            cmd.sel_rx      = (state_ff == PH_RX_SEND);
            cmd.burst_step  = stat.out_free && !stat.cnt_full;
            cmd.burst_final = stat.out_free && stat.cnt_full;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: hdl/umsbt_dpath.sv
module umsbt_dpath
   import umsbt_pkg::*;
#(
   parameter int BLOCK_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic [7:0]  frame_byte,
   input  logic [3:0]  load_index,
   input  logic [7:0]  load_value,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [7:0]  rsp_byte,
   output logic [3:0]  rsp_index,
   output logic        rsp_last
);

   localparam int CW = $clog2(BLOCK_LEN + 1);
   localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

   logic [7:0]    addr_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [7:0]    sum_ff;
   logic [7:0]    sum_in;

   logic [7:0]    rx_mem [BLOCK_LEN];
   logic [7:0]    tx_mem [BLOCK_LEN];
   logic [BLOCK_LEN-1:0] tx_valid_ff;
   logic [7:0]    rx_rd_ff;
   logic [7:0]    tx_rd_ff;
   logic          tx_rd_valid_ff;

   logic [CW-1:0] rd_idx;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          load_ok;
   logic [AW-1:0] load_addr;
   logic [7:0]    cur_byte;
   logic          emit;

   logic       rsp_valid_ff;
   logic       rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic [3:0] rsp_index_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 8'h02;
      end else if (csr_we) begin
         addr_ff <= csr_wdata;
      end
   end

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.cnt_full   = (cnt_ff == CW'(BLOCK_LEN));
   assign stat.sum_match  = (frame_byte == sum_ff);
   assign stat.addr_match = (frame_byte == addr_ff);

   // store read pointer runs one ahead of the emitted position
   assign rd_idx  = cmd.burst_start ? '0 : cnt_ff + 1'b1;
   assign rd_en   = (cmd.burst_start || cmd.burst_step) && (rd_idx < CW'(BLOCK_LEN));
   assign rd_addr = AW'(rd_idx);

   assign load_ok   = cmd.tx_load && (7'(load_index) < 7'(BLOCK_LEN));
   assign load_addr = AW'(load_index);

   assign cur_byte = cmd.sel_rx ? rx_rd_ff : (tx_rd_valid_ff ? tx_rd_ff : 8'h00);
   assign emit     = cmd.reply || cmd.burst_step || cmd.burst_final;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (cmd.rx_clear || cmd.burst_start || cmd.burst_final) begin
         cnt_in = '0;
         sum_in = '0;
      end else if (cmd.rx_store) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + frame_byte;
      end else if (cmd.burst_step) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + cur_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rx_store) begin
         rx_mem[AW'(cnt_ff)] <= frame_byte;
      end
      if (rd_en) begin
         rx_rd_ff <= rx_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         tx_mem[load_addr] <= load_value;
      end
      if (rd_en) begin
         tx_rd_ff       <= tx_mem[rd_addr];
         tx_rd_valid_ff <= tx_valid_ff[rd_addr];
      end
   end

   // unwritten transmit entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_valid_ff <= '0;
      end else if (load_ok) begin
         tx_valid_ff[load_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_kind_ff  <= KIND_LINE;
         rsp_byte_ff  <= cmd.reply_addr ? addr_ff : cmd.reply_byte;
         rsp_index_ff <= 4'd0;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.burst_step) begin
         rsp_kind_ff  <= cmd.sel_rx ? KIND_DATA : KIND_LINE;
         rsp_byte_ff  <= cur_byte;
         rsp_index_ff <= cmd.sel_rx ? 4'(cnt_ff) : 4'd0;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.burst_final) begin
         rsp_kind_ff  <= KIND_LINE;
         rsp_byte_ff  <= cmd.sel_rx ? REPLY_OK : sum_ff;
         rsp_index_ff <= 4'd0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: hdl/uart_multidrop_slave_block_transfer.sv
// channel   dir   handshake            payload
// req_bus   in    valid/ready          command frame_byte frame_bit9 load_index
//                                      load_value rx_ready tx_ready
// rsp_bus   out   valid/ready          out_kind out_byte out_index last
// csr       in    csr_we               csr_wdata (own address)
//
// a transaction with one reply or none registers its reply as its frame is accepted
// a block burst: the store read runs one entry a cycle through a registered read port,
// one result per cycle into the output register while that register is free
// reset clears the controller, counters, output valid flag and transmit valid bits
// rsp_ready low holds the burst and keeps req_bus.ready low until the register frees
module uart_multidrop_slave_block_transfer
   import umsbt_pkg::*;
#(
   parameter int BLOCK_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   umsbt_req_if.sink   req_bus,
   umsbt_rsp_if.source rsp_bus,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   assign req_bus.ready = req_ready;

   umsbt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_command    (req_bus.command),
      .req_frame_byte (req_bus.frame_byte),
      .req_frame_bit9 (req_bus.frame_bit9),
      .req_rx_ready   (req_bus.rx_ready),
      .req_tx_ready   (req_bus.tx_ready),
      .req_ready      (req_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   umsbt_dpath #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .frame_byte (req_bus.frame_byte),
      .load_index (req_bus.load_index),
      .load_value (req_bus.load_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_kind   (rsp_bus.out_kind),
      .rsp_byte   (rsp_bus.out_byte),
      .rsp_index  (rsp_bus.out_index),
      .rsp_last   (rsp_bus.last)
   );

   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      (cmd.reply || cmd.burst_step || cmd.burst_final) |-> stat.out_free)
      else $error("result issued while output register busy");

   a_one_action : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.reply, cmd.burst_start, cmd.burst_step, cmd.burst_final,
                cmd.rx_store, cmd.tx_load}))
      else $error("conflicting datapath commands");

   a_final_clears : assert property (@(posedge clock) disable iff (reset)
      cmd.burst_final |=> !stat.cnt_full)
      else $error("counter not cleared after burst");

   a_no_accept_in_burst : assert property (@(posedge clock) disable iff (reset)
      (cmd.burst_step || cmd.burst_final) |-> !req_ready)
      else $error("transaction accepted during burst");

endmodule
